FILE: rtl/core/spq_pkg.sv
package spq_pkg;

   localparam int ValueW = 32;
   localparam int PrioW  = 16;
   localparam int StatW  = 2;
   localparam int CountW = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [StatW-1:0] STAT_OK        = 2'd0;
   localparam logic [StatW-1:0] STAT_UNDERFLOW = 2'd1;
   localparam logic [StatW-1:0] STAT_FULL      = 2'd2;

   typedef struct packed {
      logic [ValueW-1:0] value;
      logic [PrioW-1:0]  prio;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } op_type;

endpackage

FILE: rtl/core/sorted_priority_queue.sv
// channel | dir | tdata fields (low bit up)
// req_    | in  | command[0], item_value[32:1], item_priority[48:33]
// rsp_    | out | status[1:0], removed_value[33:2], removed_priority[49:34],
//         |     | entry_count[54:50]
// one request per cycle; the row of cells shifts right on insert and left
// on remove in the cycle it is accepted, and the result is registered.
// reset clears the entry count and the result valid; cell contents are
// left as they are. a stalled result holds the request side only while it
// is not taken.
module sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // command, item_value, item_priority
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // status, removed_value, removed_priority, entry_count
);
   import spq_pkg::*;

   localparam int CntW = $clog2(CAPACITY + 1);

   logic [CntW-1:0] count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [54:0]     rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            cmd;
   entry_type       req_entry;
   logic            full, empty;
   op_type          op;
   logic [StatW-1:0] status;
   entry_type       removed;

   logic      ahead    [CAPACITY];
   entry_type cell_out [CAPACITY];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tdata[0];
   assign req_entry.value = req_tdata[32:1];
   assign req_entry.prio  = req_tdata[48:33];

   assign full  = (count_ff == CntW'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      op.insert = accept && (cmd == CMD_INSERT) && !full;
      op.remove = accept && (cmd == CMD_REMOVE) && !empty;
      op.entry  = req_entry;
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic      occ;
         logic      pb;
         entry_type pe;
         entry_type ne;
         assign occ = (count_ff > CntW'(i));
         if (i == 0) begin : g_first
            assign pb = 1'b0;
            assign pe = req_entry;
         end else begin : g_mid
            assign pb = ahead[i-1];
            assign pe = cell_out[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign ne = cell_out[i];
         end else begin : g_inner
            assign ne = cell_out[i+1];
         end
         spq_cell u_cell (
            .clock       (clock),
            .op          (op),
            .occupied    (occ),
            .prev_ahead  (pb),
            .prev_entry  (pe),
            .next_entry  (ne),
            .ahead       (ahead[i]),
            .entry       (cell_out[i])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (op.insert) begin
         count_in = count_ff + CntW'(1);
      end else if (op.remove) begin
         count_in = count_ff - CntW'(1);
      end

      status  = STAT_OK;
      removed = '0;
      if (cmd == CMD_INSERT) begin
         if (full) begin
            status = STAT_FULL;
         end
      end else begin
         if (empty) begin
            status = STAT_UNDERFLOW;
         end else begin
            removed = cell_out[0];
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {CountW'(count_in), removed.prio, removed.value, status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

FILE: rtl/core/spq_cell.sv
module spq_cell (
   input  logic               clock,
   input  spq_pkg::op_type    op,
   input  logic               occupied,
   input  logic               prev_ahead,
   input  spq_pkg::entry_type prev_entry,
   input  spq_pkg::entry_type next_entry,
   output logic               ahead,
   output spq_pkg::entry_type entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // new entry sorts ahead of this slot: empty, or slot priority strictly larger
   assign ahead = !occupied || (entry_ff.prio > op.entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (op.insert && ahead) begin
         entry_in = prev_ahead ? prev_entry : op.entry;
      end else if (op.remove) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: tb/tb_sorted_priority_queue.sv
module tb_sorted_priority_queue;

   import spq_pkg::*;

   localparam int Depth       = 16;
   localparam int RandomItems = 1700;
   localparam int StuckLimit  = 4000;
   localparam int HoldCycles  = 90;
   localparam int HoldAfter   = 500;

   typedef struct packed {
      logic             cmd;
      logic [ValueW-1:0] value;
      logic [PrioW-1:0]  prio;
   } queue_req_t;

   typedef struct packed {
      logic [StatW-1:0]  status;
      logic [ValueW-1:0] value;
      logic [PrioW-1:0]  prio;
      logic [CountW-1:0] count;
   } queue_rsp_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // command, item_value, item_priority
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // status, removed_value, removed_priority, entry_count

   sorted_priority_queue #(
      .CAPACITY (Depth)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stimulus and expected results
   queue_req_t pending_requests[$];
   queue_rsp_t awaited_results[$];

   // shadow of the sorted store
   logic [ValueW-1:0] held_value [Depth];
   logic [PrioW-1:0]  held_prio  [Depth];
   int                held_count = 0;

   int mismatch_count  = 0;
   int results_checked = 0;
   int requests_taken  = 0;
   int insert_total    = 0;
   int remove_total    = 0;
   int full_rejects    = 0;
   int empty_removes   = 0;
   int peak_count      = 0;
   logic req_fire      = 1'b0;

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at result %0d: %s got %h want %h",
               results_checked, what, got, want);
      mismatch_count++;
   endtask

   task automatic predict_result(input queue_req_t rq, output queue_rsp_t rs);
      int slot;
      rs = '0;
      rs.status = STAT_OK;
      if (rq.cmd == CMD_INSERT) begin
         insert_total++;
         if (held_count >= Depth) begin
            rs.status = STAT_FULL;
            full_rejects++;
         end else begin
            // ties go behind entries of equal priority
            slot = 0;
            while (slot < held_count && held_prio[slot] <= rq.prio) slot++;
            for (int i = held_count; i > slot; i--) begin
               held_value[i] = held_value[i-1];
               held_prio[i]  = held_prio[i-1];
            end
            held_value[slot] = rq.value;
            held_prio[slot]  = rq.prio;
            held_count++;
         end
      end else begin
         remove_total++;
         if (held_count == 0) begin
            rs.status = STAT_UNDERFLOW;
            empty_removes++;
         end else begin
            rs.value = held_value[0];
            rs.prio  = held_prio[0];
            for (int i = 1; i < held_count; i++) begin
               held_value[i-1] = held_value[i];
               held_prio[i-1]  = held_prio[i];
            end
            held_count--;
         end
      end
      rs.count = CountW'(held_count);
      if (held_count > peak_count) peak_count = held_count;
   endtask

   task automatic add_request(input logic cmd, input logic [ValueW-1:0] value,
                              input logic [PrioW-1:0] prio);
      queue_req_t rq;
      rq.cmd   = cmd;
      rq.value = value;
      rq.prio  = prio;
      pending_requests.push_back(rq);
   endtask

   // monitor and predictor: outputs sampled at the rising edge
   always @(posedge clock) begin
      queue_rsp_t got;
      queue_rsp_t want;
      queue_req_t rq;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[1:0];
         got.value  = rsp_tdata[33:2];
         got.prio   = rsp_tdata[49:34];
         got.count  = rsp_tdata[54:50];
         if (awaited_results.size() == 0) begin
            flag_mismatch("unexpected result, status", 32'(got.status), 32'd0);
         end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status)
               flag_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.value !== want.value)
               flag_mismatch("removed_value", got.value, want.value);
            if (got.prio !== want.prio)
               flag_mismatch("removed_priority", 32'(got.prio), 32'(want.prio));
            if (got.count !== want.count)
               flag_mismatch("entry_count", 32'(got.count), 32'(want.count));
         end
         results_checked++;
      end
      if (!reset && req_tvalid && req_tready) begin
         rq.cmd   = req_tdata[0];
         rq.value = req_tdata[32:1];
         rq.prio  = req_tdata[48:33];
         predict_result(rq, want);
         awaited_results.push_back(want);
         requests_taken++;
      end
      req_fire <= !reset && req_tvalid && req_tready;
   end

   // driver: bursts of requests with random gaps, changes at the falling edge
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      queue_req_t rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // request still on offer, hold it
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
         rq = pending_requests.pop_front();
         req_tdata  <= {7'd0, rq.prio, rq.value, rq.cmd};
         req_tvalid <= 1'b1;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver: rotating stall pattern plus one long hold-off
   int  rx_cycle  = 0;
   int  hold_left = 0;
   logic hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (!hold_done && requests_taken >= HoldAfter) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case ((rx_cycle / 128) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ((rx_cycle % 8) < 5);
            endcase
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
         $display("no progress for %0d cycles", StuckLimit);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int seg_left;
      int insert_pct;
      int pick;
      logic cmd;
      logic [PrioW-1:0] prio;

      // directed: empty remove, extreme fields, ties, fill to full, full insert
      add_request(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
      add_request(CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
      add_request(CMD_INSERT, 32'h8000_0000, 16'h0000);
      add_request(CMD_INSERT, 32'hFFFF_FFFF, 16'h0000);
      add_request(CMD_INSERT, 32'h0000_0000, 16'hFFFF);
      add_request(CMD_REMOVE, 32'h0000_0000, 16'h0000);
      add_request(CMD_REMOVE, 32'h5555_5555, 16'hAAAA);
      for (int i = 0; i < Depth - 2; i++)
         add_request(CMD_INSERT, 32'hA5A5_0000 + i, 16'(Depth - 3 - i));
      add_request(CMD_INSERT, 32'h1234_5678, 16'h0000);
      add_request(CMD_REMOVE, 32'h0, 16'h0);
      add_request(CMD_REMOVE, 32'h0, 16'h0);

      // random: segments biased towards filling, draining or balanced
      seg_left   = 0;
      insert_pct = 50;
      for (int n = 0; n < RandomItems; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
         end
         seg_left--;
         cmd  = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
         pick = $urandom_range(0, 19);
         if (pick < 12)
            prio = 16'($urandom_range(0, 7));   // narrow range for plenty of ties
         else if (pick < 17)
            prio = 16'($urandom_range(0, 65535));
         else
            prio = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         add_request(cmd, $urandom, prio);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("inserts %0d (%0d refused as full), removes %0d (%0d on an empty queue)",
               insert_total, full_rejects, remove_total, empty_removes);
      $display("%0d results checked, peak occupancy %0d of %0d",
               results_checked, peak_count, Depth);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
